// ----- src/b64d_pkg.sv -----
// ----------------------------------------------------------------------------
// Strict base64 decoder package
// Shared types, constants and the character lookup for the decoder.
// ----------------------------------------------------------------------------
package b64d_pkg;

  // Default width of the group and byte counters.
  localparam int COUNT_WIDTH_DEF = 25;

  // Width and reset value of the byte limit register.
  localparam int LIMIT_WIDTH = 24;
  localparam logic [LIMIT_WIDTH-1:0] MAX_BYTES_RESET = '1;

  // Result queue sizing. One request can produce up to four results.
  localparam int MAX_RESULTS = 4;
  localparam int QUEUE_DEPTH = 8;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int PUSH_W      = $clog2(MAX_RESULTS + 1);

  // Configuration port.
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  // The padding character.
  localparam logic [7:0] PAD_CHAR = 8'h3D;

  // Status codes reported on the final item.
  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_BAD_CHAR  = 3'd1,
    ERR_PADDING   = 3'd2,
    ERR_LENGTH    = 3'd3,
    ERR_TOO_LARGE = 3'd4
  } b64d_err_t;

  // One input request: a character and the end-of-text flag.
  typedef struct packed {
    logic [7:0] in_char;
    logic       last_char;
  } b64d_in_t;

  // One result: a data byte or the final status.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_byte;
    logic       is_status;
    b64d_err_t  err_code;
  } b64d_out_t;

  // Sextet lookup: bit 6 set marks a character outside the alphabet.
  function automatic logic [6:0] sextet_of(input logic [7:0] c);
    logic [6:0] r;
    r = 7'h40;
    if (c inside {[8'h41:8'h5A]}) begin
      r = {1'b0, 6'(c - 8'h41)};
    end else if (c inside {[8'h61:8'h7A]}) begin
      r = {1'b0, 6'(c - 8'h61 + 8'd26)};
    end else if (c inside {[8'h30:8'h39]}) begin
      r = {1'b0, 6'(c - 8'h30 + 8'd52)};
    end else if (c == 8'h2B) begin
      r = 7'd62;
    end else if (c == 8'h2F) begin
      r = 7'd63;
    end
    return r;
  endfunction

endpackage

// ----- src/b64d_decode.sv -----
// ----------------------------------------------------------------------------
// Base64 decode step
// Holds the per-text state and turns one accepted character into up to four
// results: the bytes of a finished group and the final status.
// ----------------------------------------------------------------------------
module b64d_decode
  import b64d_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         accept,
  input  b64d_in_t                     item,
  input  logic [LIMIT_WIDTH-1:0]       max_out_bytes,
  output logic [PUSH_W-1:0]            push_n,
  output b64d_out_t [MAX_RESULTS-1:0]  push_items
);

  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;
  localparam int AW = (COUNT_WIDTH > LIMIT_WIDTH) ? COUNT_WIDTH : LIMIT_WIDTH;
  localparam int TW = (COUNT_WIDTH + 2 > LIMIT_WIDTH) ? COUNT_WIDTH + 2 : LIMIT_WIDTH;

  // Per-text state.
  logic [23:0]            group_bits;
  logic [1:0]             group_pos;
  logic [1:0]             pad_count;
  logic                   padded_group_seen;
  logic [COUNT_WIDTH-1:0] group_count;
  logic [COUNT_WIDTH-1:0] byte_count;
  b64d_err_t              first_error;

  logic [23:0]            group_bits_next;
  logic [1:0]             group_pos_next;
  logic [1:0]             pad_count_next;
  logic                   padded_group_seen_next;
  logic [COUNT_WIDTH-1:0] group_count_next;
  logic [COUNT_WIDTH-1:0] byte_count_next;
  b64d_err_t              first_error_next;

  logic                   is_pad;
  logic [6:0]             sx;
  logic [5:0]             value;
  b64d_err_t              char_err;
  b64d_err_t              err_seen;
  logic                   group_done;
  logic [1:0]             nbytes;
  logic [AW-1:0]          room;
  logic                   has_room;
  logic [1:0]             emit_n;
  logic                   limit_hit;
  logic [COUNT_WIDTH:0]   byte_sum;
  logic [COUNT_WIDTH-1:0] gc_less1;
  logic [TW-1:0]          gc_times3;
  logic                   too_many_groups;
  b64d_err_t              status_err;

  // Character classification and padding rules.
  always_comb begin
    is_pad   = (item.in_char == PAD_CHAR);
    sx       = sextet_of(item.in_char);
    value    = 6'd0;
    char_err = ERR_NONE;
    pad_count_next = pad_count;
    if (is_pad) begin
      if (group_pos < 2'd2) begin
        char_err = ERR_PADDING;
      end else if (pad_count < 2'd3) begin
        pad_count_next = pad_count + 2'd1;
      end
    end else begin
      if (pad_count != 2'd0) begin
        char_err = ERR_PADDING;
      end else if (sx[6]) begin
        char_err = ERR_BAD_CHAR;
      end
      if (!sx[6]) begin
        value = sx[5:0];
      end
    end
    // Keep the first error; padding seen in an earlier group comes first.
    if (first_error != ERR_NONE) begin
      err_seen = first_error;
    end else if (group_pos == 2'd0 && padded_group_seen) begin
      err_seen = ERR_PADDING;
    end else begin
      err_seen = char_err;
    end
  end

  // Group completion, byte limit and counter updates.
  always_comb begin
    group_done = (group_pos == 2'd3);
    if (pad_count_next >= 2'd2) begin
      nbytes = 2'd1;
    end else if (pad_count_next == 2'd1) begin
      nbytes = 2'd2;
    end else begin
      nbytes = 2'd3;
    end
    has_room = AW'(byte_count) < AW'(max_out_bytes);
    room     = AW'(max_out_bytes) - AW'(byte_count);
    emit_n   = 2'd0;
    if (group_done && err_seen == ERR_NONE && has_room) begin
      emit_n = (room >= AW'(nbytes)) ? nbytes : room[1:0];
    end
    limit_hit = group_done && (err_seen == ERR_NONE) && (emit_n != nbytes);
    first_error_next = limit_hit ? ERR_TOO_LARGE : err_seen;

    byte_sum        = {1'b0, byte_count} + (COUNT_WIDTH + 1)'(emit_n);
    byte_count_next = byte_sum[COUNT_WIDTH] ? CNT_MAX : byte_sum[COUNT_WIDTH-1:0];

    group_bits_next        = {group_bits[17:0], value};
    group_pos_next         = group_pos + 2'd1;
    group_count_next       = group_count;
    padded_group_seen_next = padded_group_seen;
    if (group_done) begin
      if (group_count != CNT_MAX) begin
        group_count_next = group_count + COUNT_WIDTH'(1);
      end
      if (pad_count_next != 2'd0) begin
        padded_group_seen_next = 1'b1;
      end
    end
  end

  // Final status. Groups exceed limit/3 + 1 exactly when
  // count >= 2 and limit < 3 * (count - 1).
  always_comb begin
    gc_less1  = group_count_next - COUNT_WIDTH'(1);
    gc_times3 = TW'(gc_less1) + TW'({gc_less1, 1'b0});
    too_many_groups = (group_count_next >= COUNT_WIDTH'(2)) &&
                      (TW'(max_out_bytes) < gc_times3);
    if (!group_done) begin
      status_err = ERR_LENGTH;
    end else if (too_many_groups) begin
      status_err = ERR_TOO_LARGE;
    end else begin
      status_err = first_error_next;
    end
  end

  // Result list: emitted bytes first, then the status on the last character.
  always_comb begin
    push_n = PUSH_W'(emit_n) + PUSH_W'(item.last_char);
    for (int i = 0; i < MAX_RESULTS; i++) begin
      push_items[i] = '{out_byte: 8'd0, is_byte: 1'b0, is_status: 1'b1,
                        err_code: status_err};
      if (i < 3 && 2'(i) < emit_n) begin
        push_items[i] = '{out_byte: group_bits_next[23 - 8 * (i % 3) -: 8],
                          is_byte: 1'b1, is_status: 1'b0, err_code: ERR_NONE};
      end
    end
  end

  // State registers; the last character returns the text state to reset.
  always_ff @(posedge clk) begin
    if (rst || (accept && item.last_char)) begin
      group_bits        <= '0;
      group_pos         <= '0;
      pad_count         <= '0;
      padded_group_seen <= 1'b0;
      group_count       <= '0;
      byte_count        <= '0;
      first_error       <= ERR_NONE;
    end else if (accept) begin
      group_bits        <= group_done ? 24'd0 : group_bits_next;
      group_pos         <= group_pos_next;
      pad_count         <= group_done ? 2'd0 : pad_count_next;
      padded_group_seen <= padded_group_seen_next;
      group_count       <= group_count_next;
      byte_count        <= byte_count_next;
      first_error       <= first_error_next;
    end
  end

endmodule

// ----- src/b64d_queue.sv -----
// ----------------------------------------------------------------------------
// Result queue
// Takes up to four results in one cycle and hands them out one per cycle while pop is high.
// ----------------------------------------------------------------------------
module b64d_queue
  import b64d_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst,
  input  logic [PUSH_W-1:0]            push_n,
  input  b64d_out_t [MAX_RESULTS-1:0]  push_items,
  input  logic                         pop,
  output logic [QCNT_W-1:0]            count,
  output b64d_out_t                    head
);

  b64d_out_t [QUEUE_DEPTH-1:0] slots;
  logic [QPTR_W-1:0]           wr_ptr;
  logic [QPTR_W-1:0]           rd_ptr;
  logic [QUEUE_DEPTH-1:0]      slot_we;
  b64d_out_t [QUEUE_DEPTH-1:0] slot_data;
  logic [QPTR_W-1:0]           offset;

  // Each slot takes the result whose place after the write pointer it holds.
  always_comb begin
    for (int j = 0; j < QUEUE_DEPTH; j++) begin
      offset       = QPTR_W'(j) - wr_ptr;
      slot_we[j]   = (QCNT_W'(offset) < QCNT_W'(push_n));
      slot_data[j] = push_items[offset[PUSH_W-2:0]];
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < QUEUE_DEPTH; j++) begin
      if (slot_we[j]) begin
        slots[j] <= slot_data[j];
      end
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + QPTR_W'(push_n);
      rd_ptr <= rd_ptr + QPTR_W'(pop);
      count  <= count + QCNT_W'(push_n) - QCNT_W'(pop);
    end
  end

  assign head = slots[rd_ptr];

endmodule

// ----- src/strict_base64_decoder.sv -----
// ----------------------------------------------------------------------------
// Strict base64 decoder
// Decodes standard-alphabet base64 text, one character per request, into
// bytes and a final status item.
// ----------------------------------------------------------------------------
// The decoder takes one character per cycle while ready, decodes it in the
// cycle it is accepted and puts its results (up to three bytes when a group
// of four closes, plus the status on the last character) into an eight-entry
// result queue that delivers one result per cycle while the consumer is
// ready. The input is ready whenever the queue holds four results or fewer,
// so with an always-ready consumer a text streams at one character per cycle;
// when the consumer stalls, the queue fill sets how long the input waits.
// Bytes emitted before an error stay emitted; the consumer discards them when
// the status reports an error. The user writes the byte limit through the
// configuration port only while no text is in flight; nothing checks it.
module strict_base64_decoder
  import b64d_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  // Character requests.
  input  logic                  text_valid,
  output logic                  text_ready,
  input  b64d_in_t              text_item,
  // Results.
  output logic                  result_valid,
  input  logic                  result_ready,
  output b64d_out_t             result_item,
  // Configuration port.
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam logic [QCNT_W-1:0] READY_LIMIT = QCNT_W'(QUEUE_DEPTH - MAX_RESULTS);

  logic [LIMIT_WIDTH-1:0]       max_out_bytes;
  logic                         accept;
  logic [PUSH_W-1:0]            push_n;
  b64d_out_t [MAX_RESULTS-1:0]  push_items;
  logic [QCNT_W-1:0]            q_count;

  // Byte limit register; only paddr[2] is decoded, so every address with it clear maps here.
  always_ff @(posedge clk) begin
    if (rst) begin
      max_out_bytes <= MAX_BYTES_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
      max_out_bytes <= pwdata[LIMIT_WIDTH-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? APB_DATA_W'(max_out_bytes) : '0;

  // Accept a character while the queue has room for a full set of results.
  assign text_ready = (q_count <= READY_LIMIT);
  assign accept     = text_valid && text_ready;

  b64d_decode #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_decode (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .item          (text_item),
    .max_out_bytes (max_out_bytes),
    .push_n        (push_n),
    .push_items    (push_items)
  );

  b64d_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_n     (accept ? push_n : PUSH_W'(0)),
    .push_items (push_items),
    .pop        (result_valid && result_ready),
    .count      (q_count),
    .head       (result_item)
  );

  assign result_valid = (q_count != '0);

endmodule

// ----- src/b64d_checker.sv -----
// ----------------------------------------------------------------------------
// Strict base64 decoder checker
// Port-level assertions on the decoder, attached to the top level by bind.
// ----------------------------------------------------------------------------
module b64d_checker
  import b64d_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  text_ready,
  input logic                  result_valid,
  input logic                  result_ready,
  input b64d_out_t             result_item
);

  // After reset the queue is empty and the input is open.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!result_valid && text_ready))
    else $error("decoder not empty after reset");

  // A data byte never carries a status or an error code.
  a_byte_clean: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_item.is_byte) |->
      (!result_item.is_status && result_item.err_code == ERR_NONE))
    else $error("data byte carries status fields");

  // Every non-byte result is a status item with a zero byte.
  a_status_form: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_item.is_byte) |->
      (result_item.is_status && result_item.out_byte == 8'd0))
    else $error("malformed status item");

  // A stalled result holds its value.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_ready) |=> (result_valid && $stable(result_item)))
    else $error("stalled result changed");

endmodule

bind strict_base64_decoder b64d_checker u_checker (.*);
